// File: rtl/dsfa_pkg.sv
package dsfa_pkg;

  // Longest legal frame, checksum byte included.
  localparam int unsigned MAX_FRAME_BYTES = 16;

  localparam int unsigned CountW = 8;
  localparam int unsigned SumW   = 7;
  localparam int unsigned ValueW = 14;
  localparam int unsigned TotalW = 32;

  localparam logic [CountW-1:0] CountMax     = 8'hff;
  localparam logic [CountW-1:0] SampleFrameN = 8'd3;   // bytes before the checksum
  localparam logic [CountW-1:0] HighByteIdx  = 8'd1;
  localparam logic [CountW-1:0] LowByteIdx   = 8'd2;

  // Frame length limits, derived from MAX_FRAME_BYTES
  localparam logic [CountW:0] MaxFrameLen = (CountW + 1)'(MAX_FRAME_BYTES);

  // Configuration register indexes
  localparam logic CfgTimeout  = 1'b0;
  localparam logic CfgSelfTest = 1'b1;

  localparam logic [7:0] TimeoutReset  = 8'd100;
  localparam logic [7:0] SelfTestReset = 8'd3;

  // Request kinds
  localparam logic CmdByte = 1'b0;
  localparam logic CmdTick = 1'b1;

  // Result status codes
  localparam logic [1:0] StatNone     = 2'd0;
  localparam logic [1:0] StatSample   = 2'd1;
  localparam logic [1:0] StatValid    = 2'd2;
  localparam logic [1:0] StatMismatch = 2'd3;

endpackage

// File: rtl/dust_sensor_frame_accumulator.sv
// Dust sensor frame accumulator. Each request is either one received sensor
// byte (command 0, last_byte marks the checksum byte that closes a frame) or
// a 100 ms tick (command 1, with power_on and self_test sampled). Every
// request yields exactly one result: a frame status plus the current dust
// sample, sample total, sample count and sensor error flag. A frame is valid
// when its checksum byte equals the low 7 bits of the sum of the bytes before
// it and it is no longer than MAX_FRAME_BYTES; a valid 4-byte frame adds its
// 14-bit value to the 32-bit total unless that would overflow or 255 samples
// are already in. One request is taken per clock while the result slot is empty
// or being drained: all state updates are a single add-and-compare level between
// the input handshake and the result register, and a new request is taken in the
// same cycle a pending result is taken. Write timeout_ticks (index 0) and
// self_test_ticks (index 1) only while no result is pending.
module dust_sensor_frame_accumulator
  import dsfa_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,

  input  logic              cfg_we_i,
  input  logic              cfg_idx_i,
  input  logic [7:0]        cfg_data_i,

  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              command_i,
  input  logic [7:0]        data_byte_i,
  input  logic              last_byte_i,
  input  logic              power_on_i,
  input  logic              self_test_i,

  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [1:0]        frame_status_o,
  output logic [ValueW-1:0] sample_value_o,
  output logic [TotalW-1:0] sample_sum_o,
  output logic [7:0]        sample_count_o,
  output logic              sensor_error_o
);

  // Configuration
  logic [7:0] timeout_q, self_test_lim_q;

  // Frame state
  logic [SumW-1:0]   run_sum_q, run_sum_d;
  logic [CountW-1:0] frame_cnt_q, frame_cnt_d;
  logic [6:0]        high_q, high_d, low_q, low_d;
  logic              overlong_q, overlong_d;

  // Accumulator and silence state
  logic [ValueW-1:0] value_q, value_d;
  logic [TotalW-1:0] total_q, total_d;
  logic [7:0]        samples_q, samples_d;
  logic [7:0]        silence_q, silence_d;
  logic              error_q, error_d;

  // Result register
  logic              out_valid_q;
  logic [1:0]        status_q, status_d;

  logic              accept;
  logic [ValueW-1:0] frame_value;
  logic [TotalW:0]   total_sum;
  logic [7:0]        silence_base;
  logic              frame_bad;

  // Take a new request whenever the result slot is empty or being drained.
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  assign frame_value = {high_q, low_q};
  assign total_sum   = {1'b0, total_q} + {{(TotalW + 1 - ValueW){1'b0}}, frame_value};
  assign silence_base = (!power_on_i && !self_test_i) ? 8'd0 : silence_q;

  // Overlong, high bit set in checksum, or checksum mismatch
  assign frame_bad = overlong_q ||
                     (({1'b0, frame_cnt_q} + 9'd1) > MaxFrameLen) ||
                     data_byte_i[7] ||
                     (data_byte_i[SumW-1:0] != run_sum_q);

  always_comb begin
    run_sum_d   = run_sum_q;
    frame_cnt_d = frame_cnt_q;
    high_d      = high_q;
    low_d       = low_q;
    overlong_d  = overlong_q;
    value_d     = value_q;
    total_d     = total_q;
    samples_d   = samples_q;
    silence_d   = silence_q;
    error_d     = error_q;
    status_d    = StatNone;

    if (command_i == CmdTick) begin
      // Clear when the device is off and not testing, then advance saturating.
      silence_d = (silence_base != CountMax) ? silence_base + 8'd1 : silence_base;
      error_d   = (silence_d >= timeout_q) ||
                  (self_test_i && (silence_d >= self_test_lim_q));
    end else if (last_byte_i) begin
      if (frame_bad) begin
        status_d = StatMismatch;
      end else begin
        silence_d = '0;
        status_d  = StatValid;
        if ((frame_cnt_q == SampleFrameN) && !total_sum[TotalW] &&
            (samples_q != CountMax)) begin
          total_d   = total_sum[TotalW-1:0];
          samples_d = samples_q + 8'd1;
          value_d   = frame_value;
          status_d  = StatSample;
        end
      end
      // Drop the frame state at every frame end.
      run_sum_d   = '0;
      frame_cnt_d = '0;
      high_d      = '0;
      low_d       = '0;
      overlong_d  = 1'b0;
    end else begin
      if (frame_cnt_q == HighByteIdx) begin
        high_d = data_byte_i[6:0];
      end else if (frame_cnt_q == LowByteIdx) begin
        low_d = data_byte_i[6:0];
      end
      run_sum_d = run_sum_q + data_byte_i[SumW-1:0];
      if (({1'b0, frame_cnt_q} + 9'd2) > MaxFrameLen) begin
        overlong_d = 1'b1;
      end
      if (frame_cnt_q != CountMax) begin
        frame_cnt_d = frame_cnt_q + 8'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q       <= TimeoutReset;
      self_test_lim_q <= SelfTestReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgTimeout:  timeout_q       <= cfg_data_i;
        CfgSelfTest: self_test_lim_q <= cfg_data_i;
        default:     timeout_q       <= timeout_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_sum_q   <= '0;
      frame_cnt_q <= '0;
      high_q      <= '0;
      low_q       <= '0;
      overlong_q  <= 1'b0;
      value_q     <= '0;
      total_q     <= '0;
      samples_q   <= '0;
      silence_q   <= '0;
      error_q     <= 1'b0;
    end else if (accept) begin
      run_sum_q   <= run_sum_d;
      frame_cnt_q <= frame_cnt_d;
      high_q      <= high_d;
      low_q       <= low_d;
      overlong_q  <= overlong_d;
      value_q     <= value_d;
      total_q     <= total_d;
      samples_q   <= samples_d;
      silence_q   <= silence_d;
      error_q     <= error_d;
    end
  end

  // Hold the result until taken; state only moves on accept, so the
  // accumulator outputs stay stable while a result is stalled.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign frame_status_o = status_q;
  assign sample_value_o = value_q;
  assign sample_sum_o   = total_q;
  assign sample_count_o = samples_q;
  assign sensor_error_o = error_q;

endmodule

// File: tb/dust_sensor_frame_accumulator_tb.sv
`timescale 1ns / 100ps

module dust_sensor_frame_accumulator_tb;
  import dsfa_pkg::*;

  // One request as the sender offers it
  typedef struct packed {
    logic       command;
    logic [7:0] data_byte;
    logic       last_byte;
    logic       power_on;
    logic       self_test;
  } dust_request_t;

  // One result as the block reports it
  typedef struct packed {
    logic [1:0]        frame_status;
    logic [ValueW-1:0] sample_value;
    logic [TotalW-1:0] sample_sum;
    logic [CountW-1:0] sample_count;
    logic              sensor_error;
  } dust_reading_t;

  // Tracks frame assembly, the sample total and the silence counter, and
  // keeps the readings that the block still owes in request order.
  class dust_frame_tracker;
    logic [7:0]        timeout_lim;
    logic [7:0]        selftest_lim;
    logic [SumW-1:0]   byte_sum;
    logic [CountW-1:0] frame_len;
    logic [6:0]        hi_half;
    logic [6:0]        lo_half;
    logic              too_long;
    logic [ValueW-1:0] last_value;
    logic [TotalW-1:0] value_total;
    logic [CountW-1:0] samples;
    logic [CountW-1:0] silence;
    logic              error_flag;
    int                rejects_when_full;
    int                mismatches;
    dust_reading_t     readings_due[$];

    function new();
      timeout_lim       = TimeoutReset;
      selftest_lim      = SelfTestReset;
      byte_sum          = '0;
      frame_len         = '0;
      hi_half           = '0;
      lo_half           = '0;
      too_long          = 1'b0;
      last_value        = '0;
      value_total       = '0;
      samples           = '0;
      silence           = '0;
      error_flag        = 1'b0;
      rejects_when_full = 0;
      mismatches        = 0;
    endfunction

    function void set_limit(logic idx, logic [7:0] val);
      if (idx == CfgTimeout) timeout_lim = val;
      else selftest_lim = val;
    endfunction

    function void take_request(dust_request_t r);
      dust_reading_t     want;
      logic [TotalW-1:0] v;
      want.frame_status = StatNone;
      if (r.command == CmdTick) begin
        // Clear when the device is off and not testing, then count up.
        if (!r.power_on && !r.self_test) silence = '0;
        if (silence != CountMax) silence = silence + 1'b1;
        error_flag = (silence >= timeout_lim) || (r.self_test && silence >= selftest_lim);
      end else if (!r.last_byte) begin
        if (frame_len == HighByteIdx) hi_half = r.data_byte[6:0];
        else if (frame_len == LowByteIdx) lo_half = r.data_byte[6:0];
        byte_sum = byte_sum + r.data_byte[6:0];
        if (int'(frame_len) + 2 > int'(MAX_FRAME_BYTES)) too_long = 1'b1;
        if (frame_len != CountMax) frame_len = frame_len + 1'b1;
      end else begin
        if (too_long || int'(frame_len) + 1 > int'(MAX_FRAME_BYTES) ||
            r.data_byte[7] || r.data_byte[6:0] != byte_sum) begin
          want.frame_status = StatMismatch;
        end else begin
          silence = '0;
          want.frame_status = StatValid;
          if (frame_len == SampleFrameN) begin
            v = {{(TotalW-14){1'b0}}, hi_half, lo_half};
            if (value_total <= {TotalW{1'b1}} - v && samples != CountMax) begin
              value_total = value_total + v;
              samples = samples + 1'b1;
              last_value = v[ValueW-1:0];
              want.frame_status = StatSample;
            end else begin
              rejects_when_full++;
            end
          end
        end
        byte_sum  = '0;
        frame_len = '0;
        hi_half   = '0;
        lo_half   = '0;
        too_long  = 1'b0;
      end
      want.sample_value = last_value;
      want.sample_sum   = value_total;
      want.sample_count = samples;
      want.sensor_error = error_flag;
      readings_due.push_back(want);
    endfunction

    function void match_reading(dust_reading_t got);
      dust_reading_t want;
      if (readings_due.size() == 0) begin
        $error("result with nothing pending: status %0d", got.frame_status);
        mismatches++;
        return;
      end
      want = readings_due.pop_front();
      if (got.frame_status !== want.frame_status) begin
        $error("frame_status: expected %0d, got %0d", want.frame_status, got.frame_status);
        mismatches++;
      end
      if (got.sample_value !== want.sample_value) begin
        $error("sample_value: expected %0d, got %0d", want.sample_value, got.sample_value);
        mismatches++;
      end
      if (got.sample_sum !== want.sample_sum) begin
        $error("sample_sum: expected %0d, got %0d", want.sample_sum, got.sample_sum);
        mismatches++;
      end
      if (got.sample_count !== want.sample_count) begin
        $error("sample_count: expected %0d, got %0d", want.sample_count, got.sample_count);
        mismatches++;
      end
      if (got.sensor_error !== want.sensor_error) begin
        $error("sensor_error: expected %0d, got %0d", want.sensor_error, got.sensor_error);
        mismatches++;
      end
    endfunction
  endclass

  // Drive every input to a known value from time zero
  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              cfg_we_i    = 1'b0;
  logic              cfg_idx_i   = 1'b0;
  logic [7:0]        cfg_data_i  = '0;
  logic              in_valid_i  = 1'b0;
  logic              in_ready_o;
  logic              command_i   = 1'b0;
  logic [7:0]        data_byte_i = '0;
  logic              last_byte_i = 1'b0;
  logic              power_on_i  = 1'b0;
  logic              self_test_i = 1'b0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [1:0]        frame_status_o;
  logic [ValueW-1:0] sample_value_o;
  logic [TotalW-1:0] sample_sum_o;
  logic [7:0]        sample_count_o;
  logic              sensor_error_o;

  dust_frame_tracker tracker;

  // Idle percentages of sender and receiver, and a one-shot receiver hold-off
  int unsigned gap_pct   = 0;
  int unsigned stall_pct = 0;
  int          hold_left = 0;
  int          items_sent = 0;

  // Per-phase limits and idling; the extremes and the zero limit are among them
  logic [7:0]  timeout_plan [4] = '{8'd1, 8'd255, 8'd0, 8'd7};
  logic [7:0]  selftest_plan[4] = '{8'd255, 8'd1, 8'd0, 8'd2};
  int unsigned gap_plan     [4] = '{0, 52, 0, 7};
  int unsigned stall_plan   [4] = '{0, 0, 52, 7};

  dust_sensor_frame_accumulator DUT (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .in_valid_i,
    .in_ready_o,
    .command_i,
    .data_byte_i,
    .last_byte_i,
    .power_on_i,
    .self_test_i,
    .out_valid_o,
    .out_ready_i,
    .frame_status_o,
    .sample_value_o,
    .sample_sum_o,
    .sample_count_o,
    .sensor_error_o
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Present one request at a falling edge, optionally after random idle
  // cycles, hold it until the rising edge that accepts it, then log it.
  task automatic send_request(input dust_request_t r);
    @(negedge clk_i);
    while ($urandom_range(99) < gap_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    command_i   <= r.command;
    data_byte_i <= r.data_byte;
    last_byte_i <= r.last_byte;
    power_on_i  <= r.power_on;
    self_test_i <= r.self_test;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    tracker.take_request(r);
    items_sent++;
  endtask

  // Fields that the block ignores for a request kind still get random bits
  task automatic send_byte(input logic [7:0] b, input logic last);
    dust_request_t r;
    r.command   = CmdByte;
    r.data_byte = b;
    r.last_byte = last;
    r.power_on  = 1'($urandom_range(1));
    r.self_test = 1'($urandom_range(1));
    send_request(r);
  endtask

  task automatic send_tick(input logic pwr, input logic test);
    dust_request_t r;
    r.command   = CmdTick;
    r.data_byte = 8'($urandom_range(255));
    r.last_byte = 1'($urandom_range(1));
    r.power_on  = pwr;
    r.self_test = test;
    send_request(r);
  endtask

  // Random body, then a checksum byte; corrupt flips at least one bit of it
  task automatic send_frame(input int body_len, input bit corrupt);
    logic [7:0] b;
    logic [6:0] sum7;
    sum7 = '0;
    repeat (body_len) begin
      b = 8'($urandom_range(255));
      sum7 = sum7 + b[6:0];
      send_byte(b, 1'b0);
    end
    b = {1'b0, sum7};
    if (corrupt) b = b ^ 8'($urandom_range(1, 255));
    send_byte(b, 1'b1);
  endtask

  // Mostly well-formed sample frames; the rest are ticks, bad checksums,
  // frames around the length limit and stray bytes that break frames.
  task automatic random_burst();
    int pick;
    pick = $urandom_range(99);
    if (pick < 72) begin
      send_frame(3, 1'b0);
    end else if (pick < 80) begin
      repeat ($urandom_range(1, 6)) send_tick(1'($urandom_range(1)), 1'($urandom_range(1)));
    end else if (pick < 85) begin
      send_frame($urandom_range(0, 6), 1'b1);
    end else if (pick < 91) begin
      send_frame($urandom_range(0, MAX_FRAME_BYTES), 1'b0);
    end else if (pick < 95) begin
      send_frame($urandom_range(MAX_FRAME_BYTES, MAX_FRAME_BYTES + 6), 1'($urandom_range(1)));
    end else begin
      send_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
    end
  endtask

  // Drop valid and wait until every owed result has come back
  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (tracker.readings_due.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [7:0] val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    tracker.set_limit(idx, val);
  endtask

  // Receiver: a pending hold-off wins over random stalls
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        out_ready_i <= 1'b0;
        hold_left--;
      end else begin
        out_ready_i <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Check every accepted result against the oldest owed reading
  always @(posedge clk_i) begin : result_monitor
    dust_reading_t got;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got.frame_status = frame_status_o;
      got.sample_value = sample_value_o;
      got.sample_sum   = sample_sum_o;
      got.sample_count = sample_count_o;
      got.sensor_error = sensor_error_o;
      tracker.match_reading(got);
    end
  end

  initial begin
    int  phase_base;
    logic pwr;
    tracker = new();
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed requests at the reset limits
    send_tick(1'b0, 1'b0);             // silence from off state
    send_byte(8'h00, 1'b1);            // one-byte frame, empty body sums to zero
    send_byte(8'hff, 1'b0);            // largest dust value
    send_byte(8'hff, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'h7d, 1'b1);
    send_byte(8'h00, 1'b0);            // top bits dropped, value zero
    send_byte(8'h80, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(8'h05, 1'b0);            // checksum with bit 7 set never matches
    send_byte(8'h85, 1'b1);
    repeat (3) send_tick(1'b0, 1'b1);  // reach the self-test limit
    send_tick(1'b1, 1'b0);             // powered, below timeout: clear flag
    send_tick(1'b0, 1'b0);             // off: restart silence
    send_byte(8'h10, 1'b0);            // tick in mid-frame leaves the frame alone
    send_tick(1'b1, 1'b1);
    send_byte(8'h20, 1'b0);
    send_byte(8'h30, 1'b0);
    send_byte(8'h60, 1'b1);

    for (int ph = 0; ph < 4; ph++) begin
      drain_results();
      write_reg(CfgTimeout, timeout_plan[ph]);
      write_reg(CfgSelfTest, selftest_plan[ph]);
      gap_pct   = gap_plan[ph];
      stall_pct = stall_plan[ph];
      // Hold the receiver off while requests keep coming so the block backs up
      if (ph == 0) hold_left = 80;
      // Long silence: saturate the counter and cross the largest timeout
      if (ph == 1) begin
        repeat (260) begin
          pwr = 1'($urandom_range(1));
          send_tick(pwr, pwr ? 1'($urandom_range(1)) : 1'b1);
        end
      end
      // Frame long enough to saturate the byte count
      if (ph == 2) send_frame(270, 1'b0);
      phase_base = items_sent;
      while (items_sent - phase_base < 75) begin
        random_burst();
      end
      // The last phase also fills the sample count until it rejects
      if (ph == 3) begin
        while (tracker.rejects_when_full < 4) send_frame(3, 1'b0);
      end
    end

    drain_results();
    repeat (8) @(posedge clk_i);
    if (tracker.mismatches == 0 && tracker.readings_due.size() == 0) begin
      $display("dust_sensor_frame_accumulator_tb OK");
    end else begin
      $display("dust_sensor_frame_accumulator_tb NOT OK");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("dust_sensor_frame_accumulator_tb NOT OK");
    $finish;
  end

endmodule

// File: dust_sensor_frame_accumulator.f
rtl/dsfa_pkg.sv
rtl/dust_sensor_frame_accumulator.sv
tb/dust_sensor_frame_accumulator_tb.sv
